FILE: sv/hnorm_pkg.sv
`default_nettype none
package hnorm_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 4096;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = 13;
  localparam int WCFG_W     = 11;
  localparam int HCFG_W     = 13;
  localparam int CFG_DATA_W = 13;

  localparam int NST   = 16;
  localparam int NCOMP = 3;
  localparam int SW    = 19;
  localparam int PW    = 36;
  localparam int RW    = 52;
  localparam int QW    = 17;
  localparam int Z_RAW = 510;
  localparam int ZSQ   = Z_RAW * Z_RAW;
  localparam int T_SHIFT = 28;

  typedef enum logic [0:0] {
    CFG_FRAME_WIDTH  = 1'b0,
    CFG_FRAME_HEIGHT = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic [7:0]       height_sample;
    logic [COL_W-1:0] pixel_col;
    logic [ROW_W-1:0] pixel_row;
  } in_word_t;

  typedef struct packed {
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic [14:0]        normal_z;
    logic [COL_W-1:0]   out_col;
    logic [11:0]        out_row;
    logic               frame_done;
  } out_word_t;

  typedef struct packed {
    logic             border;
    logic             done;
    logic [COL_W-1:0] col;
    logic [11:0]      row;
    logic             sx;
    logic             sy;
  } meta_t;

endpackage
`default_nettype wire

FILE: sv/hnorm_ram.sv
`default_nettype none
module hnorm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic      [WIDTH-1:0]         rdata_a,
  output logic      [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule
`default_nettype wire

FILE: sv/heightmap_normal_generator.sv
// channel  dir  handshake            payload
// in       in   in_valid/in_stall    in_data  (height_sample, pixel_col, pixel_row)
// out      out  out_valid/out_stall  out_data (normal_x/y/z, out_col, out_row, frame_done)
// cfg      in   cfg_valid/cfg_ready  cfg_index, cfg_data
//
// one word per clock sustained while the skid stage is empty; each accepted word passes through:
// line store read, difference, squares, sixteen root/divide stages, rounding.
// the line store is one dual-read RAM holding both previous rows per column.
// synchronous reset clears control only; line store contents start undefined.
// out_stall holds the result; intake stops only once the skid stage also fills.
`default_nettype none
module heightmap_normal_generator (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire hnorm_pkg::in_word_t             in_data,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output hnorm_pkg::out_word_t                 out_data,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire hnorm_pkg::cfg_idx_t             cfg_index,
  input  wire logic [hnorm_pkg::CFG_DATA_W-1:0] cfg_data
);
  import hnorm_pkg::*;

  logic [WCFG_W-1:0] frame_width_r;
  logic [HCFG_W-1:0] frame_height_r;
  logic [WCFG_W-1:0] w_eff;
  logic [HCFG_W-1:0] h_eff;

  logic      en;
  logic      acc;
  logic      in_range;
  logic [COL_W:0] col_inc;

  logic             a_v_r;
  logic [7:0]       a_h_r;
  logic [COL_W-1:0] a_c_r;
  logic [ROW_W-1:0] a_r_r;
  logic             a_last_r;
  logic             hit_a_r, hit_b_r;
  logic [15:0]      fwd_r;
  logic [7:0]       left_r;

  logic [15:0] rd_a, rd_b;
  logic [15:0] wdata;
  logic [7:0]  above_c, above2_c, right_v;
  logic [8:0]  dx, dy;
  logic        a_emit;
  meta_t       a_meta;

  logic  b_v_r;
  meta_t b_m_r;
  logic [7:0] b_ax_r, b_ay_r;

  logic  v_r [NST+1];
  meta_t m_r [NST+1];
  logic [SW-1:0] s_r [NST+1];
  logic [RW-1:0] rem_r [NCOMP][NST+1];
  logic [PW-1:0] p_r   [NCOMP][NST+1];
  logic [QW-1:0] q_r   [NCOMP][NST+1];

  logic [RW-1:0] nrem [NCOMP][NST];
  logic [PW-1:0] np   [NCOMP][NST];
  logic [QW-1:0] nq   [NCOMP][NST];
  logic [RW-1:0] term [NCOMP][NST];

  logic [15:0] sqa, sqb;
  logic [SW-1:0] s_sum;

  logic [QW-1:0] qf [NCOMP];
  out_word_t     res;

  logic      out_v_r, skid_v_r, pop, push;
  out_word_t out_r, skid_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= WCFG_W'(1024);
      frame_height_r <= HCFG_W'(1024);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_FRAME_WIDTH:  frame_width_r  <= cfg_data[WCFG_W-1:0];
        CFG_FRAME_HEIGHT: frame_height_r <= cfg_data[HCFG_W-1:0];
        default: ;
      endcase
    end
  end

  assign w_eff = (frame_width_r > WCFG_W'(MAX_WIDTH)) ? WCFG_W'(MAX_WIDTH) : frame_width_r;
  assign h_eff = (frame_height_r > HCFG_W'(MAX_HEIGHT)) ? HCFG_W'(MAX_HEIGHT)
                                                        : frame_height_r;

  assign en       = !skid_v_r;
  assign in_stall = skid_v_r;
  assign acc      = in_valid && !in_stall;
  assign in_range = ({1'b0, in_data.pixel_col} < w_eff) && (in_data.pixel_row <= h_eff);
  assign col_inc  = {1'b0, in_data.pixel_col} + 1'b1;

  // line store: upper byte row r-2, lower byte row r-1
  hnorm_ram #(.WIDTH(16), .DEPTH(MAX_WIDTH)) u_line (
    .clk     (clk),
    .we      (en && a_v_r),
    .waddr   (a_c_r),
    .wdata   (wdata),
    .re      (en),
    .raddr_a (in_data.pixel_col),
    .raddr_b (col_inc[COL_W-1:0]),
    .rdata_a (rd_a),
    .rdata_b (rd_b)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else if (en) begin
      a_v_r <= acc && in_range;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_h_r    <= in_data.height_sample;
      a_c_r    <= in_data.pixel_col;
      a_r_r    <= in_data.pixel_row;
      a_last_r <= col_inc[COL_W];
      hit_a_r  <= a_v_r && (in_data.pixel_col == a_c_r);
      hit_b_r  <= a_v_r && (col_inc[COL_W-1:0] == a_c_r) && !col_inc[COL_W];
      fwd_r    <= wdata;
      if (a_v_r) begin
        left_r <= above_c;
      end
    end
  end

  always_comb begin
    above_c  = hit_a_r ? fwd_r[7:0]  : rd_a[7:0];
    above2_c = hit_a_r ? fwd_r[15:8] : rd_a[15:8];
    right_v  = a_last_r ? 8'd0 : (hit_b_r ? fwd_r[7:0] : rd_b[7:0]);
    wdata    = {above_c, (a_r_r < h_eff) ? a_h_r : above_c};
    dx       = {1'b0, left_r} - {1'b0, right_v};
    dy       = {1'b0, above2_c} - {1'b0, a_h_r};
    a_emit   = a_r_r != '0;
    a_meta.border = (a_c_r == '0) || ({1'b0, a_c_r} == w_eff - 1'b1)
                    || (a_r_r == ROW_W'(1)) || (a_r_r == h_eff);
    a_meta.done   = ({1'b0, a_c_r} == w_eff - 1'b1) && (a_r_r == h_eff);
    a_meta.col    = a_c_r;
    a_meta.row    = 12'(a_r_r - 1'b1);
    a_meta.sx     = dx[8];
    a_meta.sy     = dy[8];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r <= 1'b0;
    end else if (en) begin
      b_v_r <= a_v_r && a_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_m_r  <= a_meta;
      b_ax_r <= dx[8] ? 8'(-dx) : dx[7:0];
      b_ay_r <= dy[8] ? 8'(-dy) : dy[7:0];
    end
  end

  assign sqa   = b_ax_r * b_ax_r;
  assign sqb   = b_ay_r * b_ay_r;
  assign s_sum = SW'(sqa) + SW'(sqb) + SW'(ZSQ);

  // restoring root of t/s, one quotient bit a stage, p tracks q*s
  always_comb begin
    for (int j = 0; j < NCOMP; j++) begin
      for (int k = 0; k < NST; k++) begin
        term[j][k] = (RW'(p_r[j][k]) << (NST - k)) + (RW'(s_r[k]) << (2 * (NST - 1 - k)));
        if (term[j][k] <= rem_r[j][k]) begin
          nrem[j][k] = rem_r[j][k] - term[j][k];
          np[j][k]   = p_r[j][k] + (PW'(s_r[k]) << (NST - 1 - k));
          nq[j][k]   = q_r[j][k] | (QW'(1) << (NST - 1 - k));
        end else begin
          nrem[j][k] = rem_r[j][k];
          np[j][k]   = p_r[j][k];
          nq[j][k]   = q_r[j][k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= NST; k++) begin
        v_r[k] <= 1'b0;
      end
    end else if (en) begin
      v_r[0] <= b_v_r;
      for (int k = 0; k < NST; k++) begin
        v_r[k+1] <= v_r[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_r[0]      <= b_m_r;
      s_r[0]      <= s_sum;
      rem_r[0][0] <= RW'(sqa) << T_SHIFT;
      rem_r[1][0] <= RW'(sqb) << T_SHIFT;
      rem_r[2][0] <= RW'(ZSQ) << T_SHIFT;
      for (int j = 0; j < NCOMP; j++) begin
        p_r[j][0] <= '0;
        q_r[j][0] <= '0;
      end
      for (int k = 0; k < NST; k++) begin
        m_r[k+1] <= m_r[k];
        s_r[k+1] <= s_r[k];
        for (int j = 0; j < NCOMP; j++) begin
          rem_r[j][k+1] <= nrem[j][k];
          p_r[j][k+1]   <= np[j][k];
          q_r[j][k+1]   <= nq[j][k];
        end
      end
    end
  end

  // round to nearest: 4*q*s + s <= 4*rem
  always_comb begin
    for (int j = 0; j < NCOMP; j++) begin
      qf[j] = q_r[j][NST] + QW'(((RW'(p_r[j][NST]) << 2) + RW'(s_r[NST]))
                                <= (rem_r[j][NST] << 2));
    end
    res.out_col    = m_r[NST].col;
    res.out_row    = m_r[NST].row;
    res.frame_done = m_r[NST].done;
    if (m_r[NST].border) begin
      res.normal_x = '0;
      res.normal_y = '0;
      res.normal_z = 15'd16384;
    end else begin
      res.normal_x = m_r[NST].sx ? 16'(-qf[0]) : qf[0][15:0];
      res.normal_y = m_r[NST].sy ? 16'(-qf[1]) : qf[1][15:0];
      res.normal_z = qf[2][14:0];
    end
  end

  assign pop  = out_v_r && !out_stall;
  assign push = en && v_r[NST];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (skid_v_r) begin
      if (pop) begin
        skid_v_r <= 1'b0;
      end
    end else if (!out_v_r || pop) begin
      out_v_r <= push;
    end else if (push) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v_r) begin
      if (pop) begin
        out_r <= skid_r;
      end
    end else if (!out_v_r || pop) begin
      out_r <= res;
    end else begin
      skid_r <= res;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire
